// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define CRCFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be seen outside reset.
`define CRCFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `CRCFR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: hdl/crcfr_pkg.sv
// Shared types, constants and the CRC byte update of the frame receiver.
// Depends on nothing; used by the receiver and its checker.
package crcfr_pkg;

    localparam int MaxPayloadDef = 256;
    localparam logic [15:0] TimeoutReset = 16'd1000;

    localparam logic [23:0] SyncHead = 24'hF09F92;
    localparam logic [7:0]  SyncTail = 8'hA5;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h1021;
    localparam logic [15:0] TickMax = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_SYNC,
        ST_CRC,
        ST_LEN,
        ST_DATA
    } t_stage;

    typedef enum logic [1:0] {
        STATUS_GOOD,
        STATUS_CRC_ERR,
        STATUS_LEN_ERR,
        STATUS_TIMEOUT
    } t_status;

    typedef enum logic {
        OP_BYTE,
        OP_TICK
    } t_op;

    // CRC-16/CCITT-FALSE update over one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/crcfr_cfg_if.sv
// Configuration write channel: valid, ready and the timeout register value.
// Depends on nothing.
interface crcfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] timeout_ticks;

    modport source (output valid, output timeout_ticks, input ready);
    modport sink (input valid, input timeout_ticks, output ready);
endinterface

// File: hdl/crcfr_in_if.sv
// Input channel: one received byte or one time tick per item.
// Depends on nothing.
interface crcfr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// File: hdl/crcfr_out_if.sv
// Result channel: payload byte, frame end marker, status and length.
// Depends on nothing.
interface crcfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [1:0]  status;
    logic [15:0] frame_length;

    modport source (output valid, output data_byte, output byte_valid,
                    output frame_end, output status, output frame_length,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input frame_end, input status, input frame_length,
                  output ready);
endinterface

// File: hdl/crc_checked_frame_receiver.sv
// Sync word, CRC and length deframer with a CRC-16/CCITT-FALSE payload check.
// Depends on crcfr_pkg and the interfaces crcfr_cfg_if, crcfr_in_if, crcfr_out_if.
//
//   channel   direction   carries
//   i_cfg     in          timeout_ticks register write
//   i_in      in          operation (byte or tick), rx_byte
//   o_out     out         data_byte, byte_valid, frame_end, status, frame_length
//
// One item is taken every cycle while the result register is not stalled; an item
// waits in the input register, and any result that it gives is loaded into the
// result register when the item moves on.
// The frame state update between those registers (one byte of CRC, a 16-bit
// compare or two) sets the clock limit. Reset is synchronous, active low, and
// returns the receiver to sync search with the timeout at 1000 ticks.
// A stalled result only holds back the pipeline; configuration is always taken.
module crc_checked_frame_receiver #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MaxPayloadDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crcfr_cfg_if.sink    i_cfg,
    crcfr_in_if.sink     i_in,
    crcfr_out_if.source  o_out
);
    import crcfr_pkg::*;

    localparam int CntNat = $clog2(MAX_PAYLOAD + 1);
    localparam int CntW   = (CntNat > 3) ? CntNat : 3;

    // Input register
    logic       r_in_valid;
    t_op        r_in_op;
    logic [7:0] r_in_byte;

    // Frame state
    t_stage            r_stage, n_stage;
    logic [23:0]       r_hdr, n_hdr;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [15:0]       r_crc, n_crc;
    logic [15:0]       r_exp, n_exp;
    logic [15:0]       r_len, n_len;
    logic [15:0]       r_tick, n_tick;
    logic [15:0]       r_timeout;

    // Result register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_data, n_data;
    logic        r_bvalid, n_bvalid;
    logic        r_fend, n_fend;
    t_status     r_status, n_status;
    logic [15:0] r_flen, n_flen;

    logic            w_adv;
    logic            w_fire;
    logic            w_is_tick;
    logic [15:0]     w_tick_sat;
    logic            w_timeout;
    logic [CntW-1:0] w_cnt_inc;
    logic [23:0]     w_hdr_shift;
    logic [15:0]     w_field;
    logic            w_sync_ok;
    logic            w_sync_done;
    logic            w_two_done;
    logic [15:0]     w_crc_new;
    logic            w_len_bad;
    logic            w_last;

    assign i_cfg.ready = 1'b1;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    assign w_is_tick   = (r_in_op == OP_TICK);
    assign w_tick_sat  = (r_tick == TickMax) ? r_tick : r_tick + 16'd1;
    assign w_timeout   = (w_tick_sat >= r_timeout);
    assign w_cnt_inc   = r_cnt + CntW'(1);
    assign w_hdr_shift = {r_hdr[15:0], r_in_byte};
    // Two-byte fields arrive low byte first.
    assign w_field     = {w_hdr_shift[7:0], w_hdr_shift[15:8]};
    assign w_sync_ok   = (r_hdr == SyncHead) && (r_in_byte == SyncTail);
    assign w_sync_done = (w_cnt_inc == CntW'(4));
    assign w_two_done  = (w_cnt_inc == CntW'(2));
    assign w_crc_new   = crc16_byte(r_crc, r_in_byte);
    assign w_len_bad   = (w_field == 16'd0) || (32'(w_field) > 32'(MAX_PAYLOAD));
    assign w_last      = !(32'(w_cnt_inc) < 32'(r_len));

    // Next stage
    always_comb begin
        n_stage = r_stage;
        if (w_fire) begin
            if (w_is_tick) begin
                if (w_timeout) begin
                    n_stage = ST_SYNC;
                end
            end else begin
                unique case (r_stage)
                    ST_SYNC: begin
                        if (w_sync_done && w_sync_ok) begin
                            n_stage = ST_CRC;
                        end
                    end
                    ST_CRC: begin
                        if (w_two_done) begin
                            n_stage = ST_LEN;
                        end
                    end
                    ST_LEN: begin
                        if (w_two_done) begin
                            n_stage = w_len_bad ? ST_SYNC : ST_DATA;
                        end
                    end
                    ST_DATA: begin
                        if (w_last) begin
                            n_stage = ST_SYNC;
                        end
                    end
                endcase
            end
        end
    end

    // Datapath and results
    always_comb begin
        n_hdr       = r_hdr;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_exp       = r_exp;
        n_len       = r_len;
        n_tick      = r_tick;
        n_out_valid = r_out_valid && !o_out.ready;
        n_data      = r_data;
        n_bvalid    = r_bvalid;
        n_fend      = r_fend;
        n_status    = r_status;
        n_flen      = r_flen;
        if (w_fire) begin
            if (w_is_tick) begin
                n_tick = w_tick_sat;
                if (w_timeout) begin
                    n_hdr  = '0;
                    n_cnt  = '0;
                    n_tick = '0;
                    n_crc  = CrcInit;
                    n_exp  = '0;
                    n_len  = '0;
                    // A timeout before the sync word is found drops silently.
                    if (r_stage != ST_SYNC) begin
                        n_out_valid = 1'b1;
                        n_data      = '0;
                        n_bvalid    = 1'b0;
                        n_fend      = 1'b1;
                        n_status    = STATUS_TIMEOUT;
                        n_flen      = r_len;
                    end
                end
            end else begin
                unique case (r_stage)
                    ST_SYNC: begin
                        n_cnt = w_cnt_inc;
                        n_hdr = w_hdr_shift;
                        if (w_sync_done) begin
                            n_hdr  = '0;
                            n_cnt  = '0;
                            n_tick = '0;
                            n_crc  = CrcInit;
                            n_exp  = '0;
                            n_len  = '0;
                        end
                    end
                    ST_CRC: begin
                        n_hdr = w_hdr_shift;
                        n_cnt = w_cnt_inc;
                        if (w_two_done) begin
                            n_exp  = w_field;
                            n_hdr  = '0;
                            n_cnt  = '0;
                            n_tick = '0;
                        end
                    end
                    ST_LEN: begin
                        n_hdr = w_hdr_shift;
                        n_cnt = w_cnt_inc;
                        if (w_two_done) begin
                            n_hdr  = '0;
                            n_cnt  = '0;
                            n_tick = '0;
                            n_crc  = CrcInit;
                            if (w_len_bad) begin
                                n_exp       = '0;
                                n_len       = '0;
                                n_out_valid = 1'b1;
                                n_data      = '0;
                                n_bvalid    = 1'b0;
                                n_fend      = 1'b1;
                                n_status    = STATUS_LEN_ERR;
                                n_flen      = w_field;
                            end else begin
                                n_len = w_field;
                            end
                        end
                    end
                    ST_DATA: begin
                        n_crc       = w_crc_new;
                        n_cnt       = w_cnt_inc;
                        n_out_valid = 1'b1;
                        n_data      = r_in_byte;
                        n_bvalid    = 1'b1;
                        n_fend      = w_last;
                        n_flen      = r_len;
                        n_status    = STATUS_GOOD;
                        if (w_last) begin
                            if (w_crc_new != r_exp) begin
                                n_status = STATUS_CRC_ERR;
                            end
                            n_hdr  = '0;
                            n_cnt  = '0;
                            n_tick = '0;
                            n_crc  = CrcInit;
                            n_exp  = '0;
                            n_len  = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_stage     <= ST_SYNC;
            r_hdr       <= '0;
            r_cnt       <= '0;
            r_crc       <= CrcInit;
            r_exp       <= '0;
            r_len       <= '0;
            r_tick      <= '0;
            r_timeout   <= TimeoutReset;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_out_valid <= n_out_valid;
            r_stage     <= n_stage;
            r_hdr       <= n_hdr;
            r_cnt       <= n_cnt;
            r_crc       <= n_crc;
            r_exp       <= n_exp;
            r_len       <= n_len;
            r_tick      <= n_tick;
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.timeout_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op   <= t_op'(i_in.operation);
            r_in_byte <= i_in.rx_byte;
        end
        r_data   <= n_data;
        r_bvalid <= n_bvalid;
        r_fend   <= n_fend;
        r_status <= n_status;
        r_flen   <= n_flen;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data_byte    = r_data;
    assign o_out.byte_valid   = r_bvalid;
    assign o_out.frame_end    = r_fend;
    assign o_out.status       = r_status;
    assign o_out.frame_length = r_flen;

endmodule

// File: hdl/crcfr_checker.sv
// Port-level checks of the frame receiver's result channel, bound to the top.
// Depends on crcfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crcfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_byte_valid,
    input logic        i_frame_end,
    input logic [1:0]  i_status,
    input logic [15:0] i_frame_length
);
    import crcfr_pkg::*;

    // A stalled result keeps its content.
    `CRCFR_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte) && $stable(i_status) && $stable(i_frame_length), "stalled result changed")

    // Status is only carried on the item that ends a frame.
    `CRCFR_ASSERT_NEVER(a_status_no_end, i_clk, i_rst_n, i_out_valid && !i_frame_end && (i_status != STATUS_GOOD), "status without frame end")

    // Payload bytes only exist inside a frame of nonzero length.
    `CRCFR_ASSERT_NEVER(a_byte_len, i_clk, i_rst_n, i_out_valid && i_byte_valid && (i_frame_length == 16'd0), "payload byte with zero length")

    // Length errors and timeouts never carry a byte, and an empty slot holds zero.
    `CRCFR_ASSERT_NEVER(a_err_byte, i_clk, i_rst_n, i_out_valid && i_byte_valid && (i_status == STATUS_LEN_ERR || i_status == STATUS_TIMEOUT), "error result carries a byte")

    `CRCFR_ASSERT_NEVER(a_empty_zero, i_clk, i_rst_n, i_out_valid && !i_byte_valid && (i_data_byte != 8'd0), "empty byte slot not zero")

endmodule

bind crc_checked_frame_receiver crcfr_checker u_crcfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_data_byte    (o_out.data_byte),
    .i_byte_valid   (o_out.byte_valid),
    .i_frame_end    (o_out.frame_end),
    .i_status       (o_out.status),
    .i_frame_length (o_out.frame_length)
);
